FILE: design/fstp_pkg.sv
`default_nettype none

package fstp_pkg;

    localparam int TASKS = 16;
    localparam int IDX_W = $clog2(TASKS);
    localparam int CNT_W = $clog2(TASKS + 1);

    localparam int ID_W    = 16;
    localparam int PRIO_W  = 6;
    localparam int BURST_W = 16;
    localparam int VR_W    = 40;
    localparam int CFG_W   = 8;
    localparam int W_W     = PRIO_W + 1;
    localparam int AMT_W   = CFG_W + 1 + W_W;

    localparam logic [VR_W-1:0] VR_MAX = {VR_W{1'b1}};

    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_RUN = 1'b1;

    localparam logic CFG_TIME_SLICE = 1'b0;
    localparam logic CFG_IO_WAIT    = 1'b1;

    localparam logic [7:0] TIME_SLICE_RESET = 8'd1;
    localparam logic [7:0] IO_WAIT_RESET    = 8'd10;

    localparam logic [1:0] ST_ADDED  = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SERVED = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] burst;
        logic               is_io;
        logic [VR_W-1:0]    vr;
    } entry_t;

    typedef struct packed {
        logic [BURST_W-1:0] burst;
        logic               fin;
        logic [VR_W-1:0]    vr;
    } charge_t;

endpackage

`default_nettype wire

FILE: design/fstp_ram.sv
`default_nettype none

module fstp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: design/fstp_charge.sv
`default_nettype none

module fstp_charge (
    input  wire logic             clk,
    input  wire logic             load,
    input  wire fstp_pkg::entry_t entry,
    input  wire logic [7:0]       time_slice,
    input  wire logic [7:0]       io_wait,
    output fstp_pkg::charge_t     result
);

    import fstp_pkg::*;

    logic [W_W-1:0]     weight;
    logic [CFG_W:0]     units;
    logic [AMT_W-1:0]   amount;
    logic [BURST_W-1:0] burst_left;
    logic [CFG_W-1:0]   run_units;

    logic [AMT_W-1:0]   amount_reg;
    logic [BURST_W-1:0] burst_reg;
    logic               fin_reg;
    logic [VR_W-1:0]    vr_reg;
    logic [VR_W:0]      sum;

    always_comb
    begin
        weight = W_W'(entry.prio) + W_W'(1);
        if (BURST_W'(time_slice) < entry.burst)
        begin
            run_units = time_slice;
        end
        else
        begin
            run_units = entry.burst[CFG_W-1:0];
        end
        if (entry.is_io)
        begin
            units      = {1'b0, io_wait} + (CFG_W + 1)'(1);
            burst_left = (entry.burst == '0) ? '0 : entry.burst - BURST_W'(1);
        end
        else
        begin
            units      = {1'b0, run_units};
            burst_left = entry.burst - BURST_W'(run_units);
        end
        amount = AMT_W'(units) * AMT_W'(weight);
    end

    // product registered before the saturating add
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            amount_reg <= amount;
            burst_reg  <= burst_left;
            fin_reg    <= (burst_left == '0);
            vr_reg     <= entry.vr;
        end
    end

    assign sum = {1'b0, vr_reg} + (VR_W + 1)'(amount_reg);

    always_comb
    begin
        result.burst = burst_reg;
        result.fin   = fin_reg;
        result.vr    = sum[VR_W] ? VR_MAX : sum[VR_W-1:0];
    end

endmodule

`default_nettype wire

FILE: design/fair_share_task_picker.sv
`default_nettype none

// channel | direction | handshake           | beat
// in      | input     | in_valid / in_stall | action, task fields
// out     | output    | out_valid/out_stall | status, served task fields
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// a run item reads the whole table, one read per cycle through the
// single read port of the task memory, then product, saturating add, write back
// an add item scans up from slot 0 and writes the lowest free slot
// an empty run or a full-table add goes straight to the result
// reset clears the valid bits and the task count; memory contents need no clear
// one result register sits on the output; a stalled result holds the next item

module fair_share_task_picker (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [15:0] task_id,
    input  wire logic [5:0]  task_priority,
    input  wire logic [15:0] burst,
    input  wire logic        io_task,
    input  wire logic [39:0] start_vruntime,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [15:0]      served_id,
    output logic [15:0]      remaining_burst,
    output logic [39:0]      vruntime_after,
    output logic             finished,
    output logic             queue_empty,

    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [7:0]  cfg_data
);

    import fstp_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD_SCAN,
        S_RUN_SCAN,
        S_RUN_LAST,
        S_CHARGE,
        S_WRITE,
        S_DELIVER
    } state_t;

    state_t             state_reg;
    logic [7:0]         time_slice_reg;
    logic [7:0]         io_wait_reg;
    logic [TASKS-1:0]   valid_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   scan_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic               rd_pend_reg;
    logic               have_best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    entry_t             best_reg;
    entry_t             add_reg;

    logic [1:0]         res_status_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [BURST_W-1:0] res_burst_reg;
    logic [VR_W-1:0]    res_vr_reg;
    logic               res_fin_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [ID_W-1:0]    out_id_reg;
    logic [BURST_W-1:0] out_burst_reg;
    logic [VR_W-1:0]    out_vr_reg;
    logic               out_fin_reg;
    logic               out_empty_reg;

    logic [IDX_W-1:0]   vidx;
    logic               vbit;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    entry_t             ram_wdata;
    entry_t             ram_rdata;
    entry_t             wb_entry;
    charge_t            chg;
    logic               in_fire;
    logic               out_free;
    logic               take_read;

    assign in_fire   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign vidx      = (state_reg == S_ADD_SCAN) ? scan_reg : rd_idx_reg;
    assign vbit      = valid_reg[vidx];
    assign take_read = rd_pend_reg && vbit &&
                       (!have_best_reg || ram_rdata.vr < best_reg.vr);

    always_comb
    begin
        wb_entry       = best_reg;
        wb_entry.burst = chg.burst;
        wb_entry.vr    = chg.vr;
        ram_we         = 1'b0;
        ram_waddr      = best_idx_reg;
        ram_wdata      = wb_entry;
        if (state_reg == S_ADD_SCAN)
        begin
            ram_we    = !vbit;
            ram_waddr = scan_reg;
            ram_wdata = add_reg;
        end
        else if (state_reg == S_WRITE)
        begin
            ram_we = 1'b1;
        end
    end

    fstp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TASKS)
    ) u_task_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (scan_reg),
        .rdata (ram_rdata)
    );

    fstp_charge u_charge (
        .clk        (clk),
        .load       (state_reg == S_CHARGE),
        .entry      (best_reg),
        .time_slice (time_slice_reg),
        .io_wait    (io_wait_reg),
        .result     (chg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            time_slice_reg <= TIME_SLICE_RESET;
            io_wait_reg    <= IO_WAIT_RESET;
            valid_reg      <= '0;
            count_reg      <= '0;
            scan_reg       <= '0;
            rd_pend_reg    <= 1'b0;
            have_best_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TIME_SLICE: time_slice_reg <= cfg_data;
                    CFG_IO_WAIT:    io_wait_reg    <= cfg_data;
                    default:        ;
                endcase
            end

            if (out_valid_reg && !out_stall && (state_reg != S_DELIVER))
            begin
                out_valid_reg <= 1'b0;
            end

            rd_pend_reg <= (state_reg == S_RUN_SCAN);
            rd_idx_reg  <= scan_reg;

            if (take_read)
            begin
                best_reg      <= ram_rdata;
                best_idx_reg  <= rd_idx_reg;
                have_best_reg <= 1'b1;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    scan_reg      <= '0;
                    have_best_reg <= 1'b0;
                    res_id_reg    <= '0;
                    res_burst_reg <= '0;
                    res_vr_reg    <= '0;
                    res_fin_reg   <= 1'b0;
                    add_reg.id    <= task_id;
                    add_reg.prio  <= task_priority;
                    add_reg.burst <= burst;
                    add_reg.is_io <= io_task;
                    add_reg.vr    <= start_vruntime;
                    if (in_fire)
                    begin
                        if (action == ACT_ADD)
                        begin
                            if (count_reg == CNT_W'(TASKS))
                            begin
                                res_status_reg <= ST_FULL;
                                state_reg      <= S_DELIVER;
                            end
                            else
                            begin
                                res_status_reg <= ST_ADDED;
                                state_reg      <= S_ADD_SCAN;
                            end
                        end
                        else
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_DELIVER;
                            end
                            else
                            begin
                                res_status_reg <= ST_SERVED;
                                state_reg      <= S_RUN_SCAN;
                            end
                        end
                    end
                end

                S_ADD_SCAN:
                begin
                    if (!vbit)
                    begin
                        valid_reg[scan_reg] <= 1'b1;
                        count_reg           <= count_reg + CNT_W'(1);
                        state_reg           <= S_DELIVER;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IDX_W'(1);
                    end
                end

                S_RUN_SCAN:
                begin
                    if (scan_reg == IDX_W'(TASKS - 1))
                    begin
                        state_reg <= S_RUN_LAST;
                    end
                    else
                    begin
                        scan_reg <= scan_reg + IDX_W'(1);
                    end
                end

                S_RUN_LAST:
                begin
                    state_reg <= S_CHARGE;
                end

                S_CHARGE:
                begin
                    state_reg <= S_WRITE;
                end

                S_WRITE:
                begin
                    res_id_reg    <= best_reg.id;
                    res_burst_reg <= chg.burst;
                    res_vr_reg    <= chg.vr;
                    res_fin_reg   <= chg.fin;
                    if (chg.fin)
                    begin
                        valid_reg[best_idx_reg] <= 1'b0;
                        count_reg               <= count_reg - CNT_W'(1);
                    end
                    state_reg <= S_DELIVER;
                end

                S_DELIVER:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_id_reg     <= res_id_reg;
                        out_burst_reg  <= res_burst_reg;
                        out_vr_reg     <= res_vr_reg;
                        out_fin_reg    <= res_fin_reg;
                        out_empty_reg  <= (count_reg == '0);
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign served_id       = out_id_reg;
    assign remaining_burst = out_burst_reg;
    assign vruntime_after  = out_vr_reg;
    assign finished        = out_fin_reg;
    assign queue_empty     = out_empty_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TASKS))
        else $error("task count beyond table size");

    a_served_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHARGE) |-> (have_best_reg && valid_reg[best_idx_reg]))
        else $error("run finished scan without a valid pick");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> queue_empty)
        else $error("nothing queued but queue not reported empty");

    a_added_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_ADDED || status == ST_FULL)) |-> !queue_empty)
        else $error("add result reports an empty queue");

    a_fin_only_served: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && finished) |-> (status == ST_SERVED))
        else $error("finished flag on a result that served nothing");

endmodule

`default_nettype wire

FILE: verif/fstp_checker.sv
`default_nettype none

module fstp_checker
    import fstp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic               action,
    input  wire logic [ID_W-1:0]    task_id,
    input  wire logic [PRIO_W-1:0]  task_priority,
    input  wire logic [BURST_W-1:0] burst,
    input  wire logic               io_task,
    input  wire logic [VR_W-1:0]    start_vruntime,

    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         status,
    input  wire logic [ID_W-1:0]    served_id,
    input  wire logic [BURST_W-1:0] remaining_burst,
    input  wire logic [VR_W-1:0]    vruntime_after,
    input  wire logic               finished,
    input  wire logic               queue_empty,

    input  wire logic               cfg_we,
    input  wire logic               cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,

    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] left;
        logic [VR_W-1:0]    vr;
        logic               fin;
        logic               empty;
    } slice_report_t;

    entry_t          task_table [TASKS];
    logic [TASKS-1:0] live;
    logic [CFG_W-1:0] slice_len;
    logic [CFG_W-1:0] wait_units;
    slice_report_t   awaited_reports [$];
    int              mismatches;

    function automatic slice_report_t schedule_item(logic act, entry_t req);
        slice_report_t    rep;
        int               slot;
        int unsigned      amount;
        logic [VR_W:0]    total;
        logic [BURST_W-1:0] ran;
        logic [BURST_W-1:0] left;
        rep = '0;
        slot = -1;
        if (act == ACT_ADD)
        begin
            for (int i = 0; i < TASKS; i++)
                if (!live[i] && slot < 0)
                    slot = i;
            if (slot < 0)
                rep.status = ST_FULL;
            else
            begin
                live[slot] = 1'b1;
                task_table[slot] = req;
                rep.status = ST_ADDED;
            end
        end
        else
        begin
            // least runtime, lowest slot on ties
            for (int i = 0; i < TASKS; i++)
                if (live[i] && (slot < 0 || task_table[i].vr < task_table[slot].vr))
                    slot = i;
            if (slot < 0)
                rep.status = ST_EMPTY;
            else
            begin
                left = task_table[slot].burst;
                if (task_table[slot].is_io)
                begin
                    amount = (wait_units + 1) * (task_table[slot].prio + 1);
                    left = (left == 0) ? '0 : left - 1'b1;
                end
                else
                begin
                    ran = (slice_len < left) ? BURST_W'(slice_len) : left;
                    amount = ran * (task_table[slot].prio + 1);
                    left = left - ran;
                end
                total = task_table[slot].vr + amount;
                task_table[slot].vr = (total > VR_MAX) ? VR_MAX : total[VR_W-1:0];
                task_table[slot].burst = left;
                rep.fin = (left == 0);
                if (rep.fin)
                    live[slot] = 1'b0;
                rep.status = ST_SERVED;
                rep.id = task_table[slot].id;
                rep.left = left;
                rep.vr = task_table[slot].vr;
            end
        end
        rep.empty = (live == '0);
        return rep;
    endfunction

    task automatic check_field(string name, logic [VR_W-1:0] want, logic [VR_W-1:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        slice_report_t want;
        slice_report_t got;
        entry_t        req;
        if (!rst_n)
        begin
            live = '0;
            slice_len = TIME_SLICE_RESET;
            wait_units = IO_WAIT_RESET;
            awaited_reports.delete();
            mismatches = 0;
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_TIME_SLICE)
                    slice_len = cfg_data;
                else
                    wait_units = cfg_data;
            end
            if (out_valid && !out_stall)
            begin
                got = {status, served_id, remaining_burst, vruntime_after, finished, queue_empty};
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result beat, status %0d id %0h",
                                 $realtime, status, served_id);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("served_id", want.id, got.id);
                    check_field("remaining_burst", want.left, got.left);
                    check_field("vruntime_after", want.vr, got.vr);
                    check_field("finished", want.fin, got.fin);
                    check_field("queue_empty", want.empty, got.empty);
                end
            end
            if (in_valid && !in_stall)
            begin
                req = {task_id, task_priority, burst, io_task, start_vruntime};
                awaited_reports.insert(awaited_reports.size(), schedule_item(action, req));
            end
            fail_count <= mismatches;
            pending <= awaited_reports.size();
        end
    end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fstp_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [ID_W-1:0]    task_id;
    logic [PRIO_W-1:0]  task_priority;
    logic [BURST_W-1:0] burst;
    logic               io_task;
    logic [VR_W-1:0]    start_vruntime;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [ID_W-1:0]    served_id;
    logic [BURST_W-1:0] remaining_burst;
    logic [VR_W-1:0]    vruntime_after;
    logic               finished;
    logic               queue_empty;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    int fail_count;
    int pending;
    int snd_idle_pct;
    int rcv_idle_pct;
    bit hold_req;

    fair_share_task_picker uut (.*);

    fstp_checker watch (.*);

    always #10 clk = ~clk;

    task automatic offer(logic act, logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                         logic [BURST_W-1:0] work, logic io, logic [VR_W-1:0] vr);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        task_id <= id;
        task_priority <= prio;
        burst <= work;
        io_task <= io;
        start_vruntime <= vr;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // receiver side
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int                 add_pct;
        logic [CFG_W-1:0]   ts;
        logic [CFG_W-1:0]   iw;
        logic               act;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] work;
        logic [VR_W-1:0]    vr;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        action <= ACT_ADD;
        task_id <= '0;
        task_priority <= '0;
        burst <= '0;
        io_task <= 1'b0;
        start_vruntime <= '0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_TIME_SLICE;
        cfg_data <= '0;
        snd_idle_pct = 21;
        rcv_idle_pct = 59;
        hold_req = 1'b0;
        add_pct = 50;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // run on an empty table
        offer(ACT_RUN, 16'hA5C3, 6'h2A, 16'h5A3C, 1'b1, 40'hA5_5A5A_A5A5);
        // compute task with no work, served once without charge
        offer(ACT_ADD, 16'h0001, 6'd0, 16'h0000, 1'b0, 40'd0);
        offer(ACT_RUN, 16'h0000, 6'd0, 16'h0000, 1'b0, 40'd0);
        // i/o task with no work, charge saturates
        offer(ACT_ADD, 16'h0002, 6'd39, 16'h0000, 1'b1, VR_MAX - 40'd5);
        offer(ACT_RUN, 16'h0000, 6'd0, 16'h0000, 1'b0, 40'd0);
        // fill the table, the last add is rejected
        for (int k = 0; k <= TASKS; k++)
            offer(ACT_ADD, (k == 0) ? 16'hFFFF : 16'(k), (k == 0) ? 6'd63 : 6'(k % 40),
                  (k == 0) ? 16'hFFFF : 16'(k), k[0], (k == 1) ? VR_MAX : 40'd5);
        // equal runtimes, lowest slot first
        repeat (3) offer(ACT_RUN, 16'h0000, 6'd0, 16'h0000, 1'b0, 40'd0);

        for (int seg = 0; seg < 6; seg++)
        begin
            settle();
            case (seg)
                0:
                begin
                    ts = 8'd0;
                    iw = 8'd0;
                end
                1:
                begin
                    ts = 8'd255;
                    iw = 8'd255;
                end
                2:
                begin
                    ts = TIME_SLICE_RESET;
                    iw = IO_WAIT_RESET;
                end
                4:
                begin
                    ts = 8'd2;
                    iw = 8'd255;
                end
                default:
                begin
                    ts = 8'($urandom_range(1, 255));
                    iw = 8'($urandom_range(0, 255));
                end
            endcase
            write_reg(CFG_TIME_SLICE, ts);
            write_reg(CFG_IO_WAIT, iw);
            snd_idle_pct = (seg < 2) ? 21 : (seg < 4) ? 59 : 0;
            rcv_idle_pct = (seg < 2) ? 59 : (seg < 4) ? 21 : 0;
            if (seg == 4)
                hold_req = 1'b1;
            for (int n = 0; n < 275; n++)
            begin
                if (n % 40 == 0)
                begin
                    case ($urandom_range(2))
                        0: add_pct = 25;
                        1: add_pct = 50;
                        default: add_pct = 75;
                    endcase
                end
                act = ($urandom_range(99) < add_pct) ? ACT_ADD : ACT_RUN;
                prio = ($urandom_range(9) == 0) ? 6'($urandom_range(40, 63))
                                                : 6'($urandom_range(39));
                case ($urandom_range(9))
                    0: work = '0;
                    1: work = ($urandom_range(1) == 0) ? 16'hFFFF : 16'($urandom);
                    default: work = 16'($urandom_range(1, 24));
                endcase
                case ($urandom_range(7))
                    0: vr = 40'({$urandom, $urandom});
                    1: vr = VR_MAX - 40'($urandom_range(5000));
                    default: vr = 40'($urandom_range(3000));
                endcase
                offer(act, 16'($urandom), prio, work, 1'($urandom_range(1)), vr);
            end
        end

        settle();
        repeat (TASKS + 10) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
